// ===== rtl/wioe_pkg.sv =====
// Shared types, constants and command/status structs for the interval overlap block.
package wioe_pkg;

  localparam int MAX_DAYS_DEF   = 1024;
  localparam int COUNT_BITS_DEF = 16;

  // Fixed field widths of the stream and register interface.
  localparam int DAY_W     = 11;
  localparam int OUT_CNT_W = 16;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 56;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [DAY_W-1:0] DAY_COUNT_RST  = 11'd1024;
  localparam logic [DAY_W-1:0] WINDOW_LEN_RST = 11'd1;

  typedef enum logic [0:0] {
    OP_ADD  = 1'b0,
    OP_EVAL = 1'b1
  } opcode_t;

  typedef enum logic [0:0] {
    REG_DAY_COUNT  = 1'b0,
    REG_WINDOW_LEN = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic accept;
    logic sweep_init;
    logic add_rd;
    logic add_wr;
    logic sweep_rd;
    logic load_out;
    logic clr_step;
  } wioe_cmd_t;

  typedef struct packed {
    logic win_ok;
    logic rd_last;
    logic out_free;
    logic clr_last;
  } wioe_status_t;

endpackage

// ===== rtl/wioe_ctrl.sv =====
// Controller state machine: add, sweep, result and clearing sequencing.
module wioe_ctrl
  import wioe_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_opcode,
  output logic         in_tready,
  input  wioe_status_t status,
  output wioe_cmd_t    cmd
);

  typedef enum logic [2:0] {
    CLEAR,
    IDLE,
    ADD_RD,
    ADD_WR,
    SWEEP,
    TAIL,
    DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_tready = (state_r == IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    cmd            = '0;
    cmd.accept     = accept;
    cmd.sweep_init = accept && (opcode_t'(in_opcode) == OP_EVAL);
    state_nxt      = state_r;
    unique case (state_r)
      CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          state_nxt = IDLE;
        end
      end
      IDLE: begin
        if (accept) begin
          if (opcode_t'(in_opcode) == OP_EVAL) begin
            state_nxt = status.win_ok ? SWEEP : DONE;
          end else begin
            state_nxt = ADD_RD;
          end
        end
      end
      ADD_RD: begin
        cmd.add_rd = 1'b1;
        state_nxt  = ADD_WR;
      end
      ADD_WR: begin
        cmd.add_wr = 1'b1;
        state_nxt  = IDLE;
      end
      SWEEP: begin
        cmd.sweep_rd = 1'b1;
        if (status.rd_last) begin
          state_nxt = TAIL;
        end
      end
      TAIL: begin
        // The last day's read data is folded into the running count here.
        state_nxt = DONE;
      end
      DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = CLEAR;
        end
      end
      default: begin
        state_nxt = CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/wioe_datapath.sv =====
// Datapath: tally memories, sweep pipeline, extreme tracking and result register.
module wioe_datapath
  import wioe_pkg::*;
#(
  parameter int MAX_DAYS   = MAX_DAYS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  wioe_cmd_t             cmd,
  output wioe_status_t          status,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [DAY_W-1:0]      day_count,
  input  logic [DAY_W-1:0]      window_len,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser
);

  localparam int AW = $clog2(MAX_DAYS);
  localparam int CW = COUNT_BITS;
  localparam logic [CW-1:0] CNT_MAX   = {CW{1'b1}};
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_DAYS - 1);

  function automatic logic [AW-1:0] day_addr(input logic [31:0] d);
    logic [31:0] t;
    t = d - 32'd1;
    return t[AW-1:0];
  endfunction

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [OUT_CNT_W-1:0] cnt_out(input logic [CW-1:0] c);
    logic [31:0] t;
    t = 32'(c);
    return t[OUT_CNT_W-1:0];
  endfunction

  logic [CW-1:0] start_mem [MAX_DAYS];
  logic [CW-1:0] end_mem   [MAX_DAYS];

  logic [DAY_W-1:0] js;
  logic [DAY_W-1:0] je;
  logic             add_ok;
  logic [AW-1:0]    js_addr_r;
  logic [AW-1:0]    je_addr_r;
  logic             add_ok_r;

  logic [DAY_W-1:0] days_eff;
  logic             win_ok;

  logic [DAY_W-1:0] rd_day_r;
  logic             rd_sub;
  logic [AW-1:0]    st_raddr;
  logic [AW-1:0]    en_raddr;
  logic [CW-1:0]    st_q;
  logic [CW-1:0]    en_q;

  logic             pvld_r;
  logic [DAY_W-1:0] pday_r;
  logic             psub_r;

  logic [CW-1:0]    run_r;
  logic             seen_r;
  logic [CW-1:0]    hi_cnt_r;
  logic [CW-1:0]    lo_cnt_r;
  logic [DAY_W-1:0] hi_day_r;
  logic [DAY_W-1:0] lo_day_r;
  logic             valid_r;

  logic [CW:0]      sum;
  logic [CW-1:0]    run_add;
  logic [CW-1:0]    run_new;
  logic             in_win;
  logic [DAY_W-1:0] first_day;

  logic [AW-1:0]    clr_addr_r;

  logic                  out_vld_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_user_r;

  assign js     = in_tdata[10:0];
  assign je     = in_tdata[21:11];
  assign add_ok = (js != '0) && (je >= js) && (32'(je) <= 32'(MAX_DAYS));

  assign days_eff = (32'(day_count) > 32'(MAX_DAYS)) ? DAY_W'(MAX_DAYS) : day_count;
  assign win_ok   = (days_eff != '0) && (window_len != '0) && (window_len <= days_eff);

  // The end tally of the day just left behind is read once the window is full.
  assign rd_sub   = rd_day_r > window_len;
  assign st_raddr = cmd.add_rd ? js_addr_r : day_addr(32'(rd_day_r));
  assign en_raddr = cmd.add_rd ? je_addr_r :
                    (rd_sub ? day_addr(32'(rd_day_r) - 32'(window_len)) : '0);

  always_ff @(posedge clk) begin
    st_q <= start_mem[st_raddr];
    en_q <= end_mem[en_raddr];
    if (cmd.clr_step) begin
      start_mem[clr_addr_r] <= '0;
      end_mem[clr_addr_r]   <= '0;
    end else if (cmd.add_wr && add_ok_r) begin
      start_mem[js_addr_r] <= sat_inc(st_q);
      end_mem[je_addr_r]   <= sat_inc(en_q);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      js_addr_r <= day_addr(32'(js));
      je_addr_r <= day_addr(32'(je));
      add_ok_r  <= add_ok;
    end
  end

  assign sum       = {1'b0, run_r} + {1'b0, st_q};
  assign run_add   = sum[CW] ? CNT_MAX : sum[CW-1:0];
  assign run_new   = psub_r ? ((run_add > en_q) ? run_add - en_q : '0) : run_add;
  assign in_win    = pday_r >= window_len;
  assign first_day = pday_r - window_len + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r <= 1'b0;
    end else begin
      pvld_r <= cmd.sweep_rd;
    end
  end

  always_ff @(posedge clk) begin
    pday_r <= rd_day_r;
    psub_r <= rd_sub;
    if (cmd.sweep_init) begin
      rd_day_r <= 11'd1;
      run_r    <= '0;
      seen_r   <= 1'b0;
      hi_cnt_r <= '0;
      lo_cnt_r <= '0;
      hi_day_r <= '0;
      lo_day_r <= '0;
      valid_r  <= win_ok;
    end else begin
      if (cmd.sweep_rd) begin
        rd_day_r <= rd_day_r + 1'b1;
      end
      if (pvld_r) begin
        run_r <= run_new;
        if (in_win) begin
          seen_r <= 1'b1;
          if (!seen_r || run_new < lo_cnt_r) begin
            lo_cnt_r <= run_new;
            lo_day_r <= first_day;
          end
          if (!seen_r || run_new > hi_cnt_r) begin
            hi_cnt_r <= run_new;
            hi_day_r <= first_day;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_addr_r <= (clr_addr_r == LAST_ADDR) ? '0 : clr_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= {2'b00, cnt_out(lo_cnt_r), cnt_out(hi_cnt_r), lo_day_r, hi_day_r};
      out_user_r <= valid_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign status.win_ok   = win_ok;
  assign status.rd_last  = (rd_day_r == days_eff);
  assign status.out_free = !out_vld_r || out_tready;
  assign status.clr_last = (clr_addr_r == LAST_ADDR);

endmodule

// ===== rtl/window_interval_overlap_extremes.sv =====
// Top level of the sliding window interval overlap extremes block.
//
//  Channel  Role    Handshake                Payload
//  in_      slave   in_tvalid / in_tready    tdata: job_start, job_end; tuser: opcode
//  out_     master  out_tvalid / out_tready  tdata: busiest/quietest start, counts; tuser: valid
//  cfg_     APB     psel, penable, pready=1  day_count at 0x0, window_len at 0x4
//
// An add request steps through accept, tally read and tally write.
// An evaluate request with a fitting window sweeps every configured day (one day per cycle through the
// registered tally reads); without one it skips the sweep. Both tallies are then zeroed
// at all MAX_DAYS addresses; after reset the same clearing pass runs before in_tready rises.
// The result sits in an output register; the block waits before loading a new
// result while the previous one is still valid and out_tready is low.
module window_interval_overlap_extremes
  import wioe_pkg::*;
#(
  parameter int MAX_DAYS   = MAX_DAYS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [10:0] job_start, [21:11] job_end
  input  logic                  in_tuser,   // [0] opcode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [10:0] busiest_start, [21:11] quietest_start,
                                            // [37:22] most_overlap, [53:38] least_overlap
  output logic                  out_tuser   // [0] result_valid
);

  logic [DAY_W-1:0] day_count_r;
  logic [DAY_W-1:0] window_len_r;
  reg_idx_t         cfg_idx;
  wioe_cmd_t        cmd;
  wioe_status_t     status;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_count_r  <= DAY_COUNT_RST;
      window_len_r <= WINDOW_LEN_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      unique case (cfg_idx)
        REG_DAY_COUNT:  day_count_r  <= cfg_pwdata[DAY_W-1:0];
        REG_WINDOW_LEN: window_len_r <= cfg_pwdata[DAY_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_DAY_COUNT:  cfg_prdata = {{(CFG_DATA_W-DAY_W){1'b0}}, day_count_r};
      REG_WINDOW_LEN: cfg_prdata = {{(CFG_DATA_W-DAY_W){1'b0}}, window_len_r};
    endcase
  end

  wioe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_opcode (in_tuser),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  wioe_datapath #(
    .MAX_DAYS   (MAX_DAYS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tdata   (in_tdata),
    .day_count  (day_count_r),
    .window_len (window_len_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== rtl/wioe_checker.sv =====
// Port-level checker for the interval overlap block, bound to the top level.
module wioe_checker
  import wioe_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  cfg_psel,
  input logic                  cfg_penable,
  input logic                  cfg_pwrite,
  input logic [CFG_ADDR_W-1:0] cfg_paddr,
  input logic [CFG_DATA_W-1:0] cfg_pwdata,
  input logic [CFG_DATA_W-1:0] cfg_prdata,
  input logic                  cfg_pready,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_DATA_W-1:0]  in_tdata,
  input logic                  in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Every accepted request keeps the block busy in the cycle after it is accepted.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after an accepted request");

  // A new result appears only while the tallies are being cleared.
  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !in_tready)
    else $error("result appeared while the input side was idle");

  // A result without a fitting window carries all-zero fields.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("invalid result with nonzero fields");

  // A valid result names real window starts.
  a_valid_days: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[10:0] != 11'd0 && out_tdata[21:11] != 11'd0)
    else $error("valid result with a zero window start");

endmodule

bind window_interval_overlap_extremes wioe_checker u_wioe_checker (.*);
